/* src/i2c_master_mem16_transactions_core_macros.svh */
// ----------------------------------------------------------------------------
// I2C master assertion macros
// Shared concurrent assertion helpers for the I2C master core.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_MEM16_TRANSACTIONS_CORE_MACROS_SVH
`define I2C_MASTER_MEM16_TRANSACTIONS_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define I2CM_ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define I2CM_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define I2CM_ASSERT_IMPLIES(label, clk, rst, a, c)
`define I2CM_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

/* src/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master package
// Payload types, request, status and bus phase codes for the I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_PROBE  = 3'd1;
   localparam logic [2:0] REQ_READ   = 3'd2;
   localparam logic [2:0] REQ_WRITE  = 3'd3;
   localparam logic [2:0] REQ_SUPPLY = 3'd4;

   localparam logic [1:0] MODE_PROBE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NACK = 2'd1;
   localparam logic [1:0] ST_BUSY = 2'd2;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_TXBIT = 3'd2;
   localparam logic [2:0] PH_TXACK = 3'd3;
   localparam logic [2:0] PH_RXBIT = 3'd4;
   localparam logic [2:0] PH_RXACK = 3'd5;
   localparam logic [2:0] PH_STOP  = 3'd6;
   localparam logic [2:0] PH_WAIT  = 3'd7;

   localparam logic [2:0] STG_ADDR_W  = 3'd0;
   localparam logic [2:0] STG_REG_HI  = 3'd1;
   localparam logic [2:0] STG_REG_LO  = 3'd2;
   localparam logic [2:0] STG_ADDR_R  = 3'd3;
   localparam logic [2:0] STG_DATA_W  = 3'd4;
   localparam logic [2:0] STG_RX_HI   = 3'd5;
   localparam logic [2:0] STG_RX_LO   = 3'd6;

   localparam logic [10:0] MAX_COUNT        = 11'd1024;
   localparam logic [15:0] HALF_PERIOD_INIT = 16'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [6:0]  dev_addr;
      logic [15:0] reg_addr;
      logic [10:0] xfer_count;
      logic [7:0]  wr_byte;
      logic        sda_in;
   } i2cm_req_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_level;
      logic        need_byte;
      logic        word_valid;
      logic [15:0] word_data;
      logic        last_word;
      logic        done_res;
      logic [1:0]  status;
   } i2cm_rsp_type;

endpackage

/* src/i2c_master_mem16_transactions_core.sv */
// A request transfer is held in the input register and is then written to the result
// register when the engine takes it; the result stays there until it is taken.
// Throughput: one item per cycle while the result side does not stall; the bus state
// update is a single pass between the input register and the result register.
// Reset: synchronous, active high; bus idle with both lines released,
// half period back to 4 ticks, no result pending.
// ----------------------------------------------------------------------------
// I2C master with 16-bit register address
// Tick-paced I2C master offering probe, word read and byte write transfers.
// ----------------------------------------------------------------------------
module i2c_master_mem16_transactions_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  i2cm_pkg::i2cm_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output i2cm_pkg::i2cm_rsp_type rsp_data
);

   logic                   item_valid;
   logic                   item_take;
   i2cm_pkg::i2cm_req_type item_data;

   i2cm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   i2cm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item_data   (item_data),
      .item_take   (item_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

/* src/i2cm_in_stage.sv */
// ----------------------------------------------------------------------------
// I2C master input stage
// Registers one request transfer and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module i2cm_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  i2cm_pkg::i2cm_req_type req_data,
   input  logic                  item_take,
   output logic                  item_valid,
   output i2cm_pkg::i2cm_req_type item_data
);

   logic                   valid_ff;
   i2cm_pkg::i2cm_req_type data_ff;

   assign req_stall  = valid_ff && !item_take;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         data_ff <= req_data;
      end
   end

endmodule

/* src/i2cm_engine.sv */
// ----------------------------------------------------------------------------
// I2C master engine
// Bus state update for one item per cycle while the result is not stalled, and the registered result stage.
// ----------------------------------------------------------------------------
`include "i2c_master_mem16_transactions_core_macros.svh"

module i2cm_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   item_valid,
   input  i2cm_pkg::i2cm_req_type item_data,
   output logic                   item_take,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output i2cm_pkg::i2cm_rsp_type rsp_data
);

   logic [15:0] half_period_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  half_ff, half_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  stage_ff, stage_in;
   logic [1:0]  mode_ff, mode_in;
   logic        fail_ff, fail_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] word_ff, word_in;
   logic [15:0] regaddr_ff, regaddr_in;
   logic [10:0] left_ff, left_in;
   logic [6:0]  target_ff, target_in;
   logic        rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::i2cm_rsp_type rsp_ff, rsp_in;

   logic [16:0] tick_next;
   logic [10:0] left_dec;
   logic [10:0] cnt;
   logic [3:0]  bit_inc;
   logic        scl, sda, nack;
   logic        wv, lw, done;
   logic [15:0] wd;
   logic [1:0]  st;

   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign tick_next = {1'b0, tick_ff} + 17'd1;
   assign left_dec  = (left_ff != 11'd0) ? left_ff - 11'd1 : left_ff;
   assign bit_inc   = bit_ff + 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      half_in    = half_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      stage_in   = stage_ff;
      mode_in    = mode_ff;
      fail_in    = fail_ff;
      tick_in    = tick_ff;
      word_in    = word_ff;
      regaddr_in = regaddr_ff;
      left_in    = left_ff;
      target_in  = target_ff;
      wv   = 1'b0;
      wd   = 16'h0000;
      lw   = 1'b0;
      done = 1'b0;
      st   = i2cm_pkg::ST_OK;
      cnt  = item_data.xfer_count;
      if (cnt == 11'd0) begin
         cnt = 11'd1;
      end
      if (cnt > i2cm_pkg::MAX_COUNT) begin
         cnt = i2cm_pkg::MAX_COUNT;
      end

      case (item_data.req_type)
         i2cm_pkg::REQ_TICK: begin
            if (phase_ff != i2cm_pkg::PH_IDLE && phase_ff != i2cm_pkg::PH_WAIT) begin
               if (tick_next >= {1'b0, half_period_ff}) begin
                  tick_in = 16'd0;
                  case (phase_ff)
                     i2cm_pkg::PH_START: begin
                        if (half_ff < 2'd3) begin
                           half_in = half_ff + 2'd1;
                        end else begin
                           phase_in = i2cm_pkg::PH_TXBIT;
                           half_in  = 2'd0;
                           bit_in   = 4'd0;
                        end
                     end
                     i2cm_pkg::PH_TXBIT: begin
                        if (half_ff == 2'd0) begin
                           half_in = 2'd1;
                        end else begin
                           shift_in = {shift_ff[6:0], 1'b0};
                           bit_in   = bit_inc;
                           half_in  = 2'd0;
                           if (bit_inc >= 4'd8) begin
                              phase_in = i2cm_pkg::PH_TXACK;
                              bit_in   = 4'd0;
                           end
                        end
                     end
                     i2cm_pkg::PH_TXACK: begin
                        if (half_ff == 2'd0) begin
                           half_in = 2'd1;
                        end else if (item_data.sda_in) begin
                           fail_in  = 1'b1;
                           phase_in = i2cm_pkg::PH_STOP;
                           half_in  = 2'd0;
                        end else begin
                           half_in = 2'd0;
                           case (stage_ff)
                              i2cm_pkg::STG_ADDR_W: begin
                                 if (mode_ff == i2cm_pkg::MODE_PROBE) begin
                                    phase_in = i2cm_pkg::PH_STOP;
                                 end else begin
                                    stage_in = i2cm_pkg::STG_REG_HI;
                                    phase_in = i2cm_pkg::PH_TXBIT;
                                    bit_in   = 4'd0;
                                    shift_in = regaddr_ff[15:8];
                                 end
                              end
                              i2cm_pkg::STG_REG_HI: begin
                                 stage_in = i2cm_pkg::STG_REG_LO;
                                 phase_in = i2cm_pkg::PH_TXBIT;
                                 bit_in   = 4'd0;
                                 shift_in = regaddr_ff[7:0];
                              end
                              i2cm_pkg::STG_REG_LO: begin
                                 if (mode_ff == i2cm_pkg::MODE_READ) begin
                                    stage_in = i2cm_pkg::STG_ADDR_R;
                                    phase_in = i2cm_pkg::PH_START;
                                    shift_in = {target_ff, 1'b1};
                                 end else begin
                                    stage_in = i2cm_pkg::STG_DATA_W;
                                    phase_in = i2cm_pkg::PH_WAIT;
                                 end
                              end
                              i2cm_pkg::STG_ADDR_R: begin
                                 stage_in = i2cm_pkg::STG_RX_HI;
                                 phase_in = i2cm_pkg::PH_RXBIT;
                                 bit_in   = 4'd0;
                              end
                              i2cm_pkg::STG_DATA_W: begin
                                 left_in = left_dec;
                                 if (left_dec == 11'd0) begin
                                    phase_in = i2cm_pkg::PH_STOP;
                                 end else begin
                                    phase_in = i2cm_pkg::PH_WAIT;
                                 end
                              end
                              default: begin
                                 phase_in = i2cm_pkg::PH_STOP;
                              end
                           endcase
                        end
                     end
                     i2cm_pkg::PH_RXBIT: begin
                        if (half_ff == 2'd0) begin
                           half_in = 2'd1;
                        end else begin
                           shift_in = {shift_ff[6:0], item_data.sda_in};
                           bit_in   = bit_inc;
                           half_in  = 2'd0;
                           if (bit_inc >= 4'd8) begin
                              phase_in = i2cm_pkg::PH_RXACK;
                              bit_in   = 4'd0;
                           end
                        end
                     end
                     i2cm_pkg::PH_RXACK: begin
                        if (half_ff == 2'd0) begin
                           half_in = 2'd1;
                        end else if (stage_ff == i2cm_pkg::STG_RX_HI) begin
                           word_in  = {shift_ff, 8'h00};
                           stage_in = i2cm_pkg::STG_RX_LO;
                           phase_in = i2cm_pkg::PH_RXBIT;
                           half_in  = 2'd0;
                           bit_in   = 4'd0;
                        end else begin
                           word_in = {word_ff[15:8], shift_ff};
                           wv      = 1'b1;
                           wd      = {word_ff[15:8], shift_ff};
                           lw      = (left_ff <= 11'd1);
                           left_in = left_dec;
                           half_in = 2'd0;
                           if (left_dec == 11'd0) begin
                              phase_in = i2cm_pkg::PH_STOP;
                           end else begin
                              stage_in = i2cm_pkg::STG_RX_HI;
                              phase_in = i2cm_pkg::PH_RXBIT;
                              bit_in   = 4'd0;
                           end
                        end
                     end
                     i2cm_pkg::PH_STOP: begin
                        if (half_ff == 2'd0) begin
                           half_in = 2'd1;
                        end else begin
                           phase_in = i2cm_pkg::PH_IDLE;
                           half_in  = 2'd0;
                           done     = 1'b1;
                           st       = fail_ff ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else begin
                  tick_in = tick_next[15:0];
               end
            end
         end
         i2cm_pkg::REQ_PROBE, i2cm_pkg::REQ_READ, i2cm_pkg::REQ_WRITE: begin
            if (phase_ff == i2cm_pkg::PH_IDLE) begin
               mode_in    = item_data.req_type[1:0];
               target_in  = item_data.dev_addr;
               regaddr_in = item_data.reg_addr;
               left_in    = cnt;
               stage_in   = i2cm_pkg::STG_ADDR_W;
               fail_in    = 1'b0;
               bit_in     = 4'd0;
               shift_in   = {item_data.dev_addr, 1'b0};
               phase_in   = i2cm_pkg::PH_START;
               half_in    = 2'd1;
               tick_in    = 16'd0;
            end else begin
               st = i2cm_pkg::ST_BUSY;
            end
         end
         i2cm_pkg::REQ_SUPPLY: begin
            if (phase_ff == i2cm_pkg::PH_WAIT) begin
               phase_in = i2cm_pkg::PH_TXBIT;
               half_in  = 2'd0;
               bit_in   = 4'd0;
               shift_in = item_data.wr_byte;
               tick_in  = 16'd0;
            end else begin
               st = i2cm_pkg::ST_BUSY;
            end
         end
         default: begin
         end
      endcase
   end

   // line drive from the state after the item
   always_comb begin
      nack = (stage_in == i2cm_pkg::STG_RX_LO) && (left_in <= 11'd1);
      case (phase_in)
         i2cm_pkg::PH_START: begin
            scl = (half_in == 2'd1) || (half_in == 2'd2);
            sda = (half_in < 2'd2);
         end
         i2cm_pkg::PH_TXBIT: begin
            scl = half_in[0];
            sda = shift_in[7];
         end
         i2cm_pkg::PH_TXACK, i2cm_pkg::PH_RXBIT: begin
            scl = half_in[0];
            sda = 1'b1;
         end
         i2cm_pkg::PH_RXACK: begin
            scl = half_in[0];
            sda = nack;
         end
         i2cm_pkg::PH_STOP: begin
            scl = half_in[0];
            sda = 1'b0;
         end
         i2cm_pkg::PH_WAIT: begin
            scl = 1'b0;
            sda = 1'b1;
         end
         default: begin
            scl = 1'b1;
            sda = 1'b1;
         end
      endcase
      rsp_in.scl_level  = scl;
      rsp_in.sda_level  = sda;
      rsp_in.need_byte  = (phase_in == i2cm_pkg::PH_WAIT);
      rsp_in.word_valid = wv;
      rsp_in.word_data  = wd;
      rsp_in.last_word  = lw;
      rsp_in.done_res   = done;
      rsp_in.status     = st;
   end

   always_comb begin
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cm_pkg::HALF_PERIOD_INIT;
      end else if (csr_wr_en) begin
         half_period_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         half_ff      <= 2'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         stage_ff     <= i2cm_pkg::STG_ADDR_W;
         mode_ff      <= 2'd0;
         fail_ff      <= 1'b0;
         tick_ff      <= 16'd0;
         word_ff      <= 16'd0;
         regaddr_ff   <= 16'd0;
         left_ff      <= 11'd0;
         target_ff    <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            phase_ff   <= phase_in;
            half_ff    <= half_in;
            bit_ff     <= bit_in;
            shift_ff   <= shift_in;
            stage_ff   <= stage_in;
            mode_ff    <= mode_in;
            fail_ff    <= fail_in;
            tick_ff    <= tick_in;
            word_ff    <= word_in;
            regaddr_ff <= regaddr_in;
            left_ff    <= left_in;
            target_ff  <= target_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
   end

   `I2CM_ASSERT_IMPLIES(a_done_idle, clock, reset, rsp_valid_ff && rsp_ff.done_res, phase_ff == i2cm_pkg::PH_IDLE)
   `I2CM_ASSERT_IMPLIES(a_need_wait, clock, reset, rsp_valid_ff, rsp_ff.need_byte == (phase_ff == i2cm_pkg::PH_WAIT))
   `I2CM_ASSERT_IMPLIES(a_word_more, clock, reset, rsp_valid_ff && rsp_ff.word_valid && !rsp_ff.last_word, phase_ff == i2cm_pkg::PH_RXBIT)
   `I2CM_ASSERT_NEXT(a_hold_state, clock, reset, !item_take, $stable(phase_ff) && $stable(left_ff))

endmodule

/* tb/i2c_master_mem16_transactions_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master with 16-bit register address: testbench
// Drives tick, probe, read, write, byte and spare requests over the request channel
// and follows every transfer with an in-bench copy of the bus state machine.
// Each result is checked field by field, in order, against that copy or a table entry.
// ----------------------------------------------------------------------------
module i2c_master_mem16_transactions_core_tb;

   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_MID   = 3'd6;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 50000;

   localparam i2cm_pkg::i2cm_rsp_type RSP_IDLE =
      '{1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, i2cm_pkg::ST_OK};
   localparam i2cm_pkg::i2cm_rsp_type RSP_REFUSED =
      '{1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, i2cm_pkg::ST_BUSY};
   localparam i2cm_pkg::i2cm_rsp_type RSP_PREDICT = '0;

   localparam logic [2:0] R_TICK   = i2cm_pkg::REQ_TICK;
   localparam logic [2:0] R_PROBE  = i2cm_pkg::REQ_PROBE;
   localparam logic [2:0] R_READ   = i2cm_pkg::REQ_READ;
   localparam logic [2:0] R_WRITE  = i2cm_pkg::REQ_WRITE;
   localparam logic [2:0] R_SUPPLY = i2cm_pkg::REQ_SUPPLY;

   typedef struct packed {
      i2cm_pkg::i2cm_req_type item;
      logic                   typed;
      i2cm_pkg::i2cm_rsp_type rsp;
   } dir_row_type;

   localparam int DIR_ROWS = 25;
   localparam dir_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b1, RSP_IDLE},
      '{'{R_TICK, 7'h7F, 16'hFFFF, 11'h7FF, 8'hFF, 1'b1}, 1'b1, RSP_IDLE},
      '{'{R_SUPPLY, 7'h00, 16'h0000, 11'h000, 8'hFF, 1'b0}, 1'b1, RSP_REFUSED},
      '{'{REQ_SPARE_LAST, 7'h7F, 16'hFFFF, 11'h7FF, 8'hFF, 1'b1}, 1'b1, RSP_IDLE},
      '{'{REQ_SPARE_FIRST, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b1, RSP_IDLE},
      '{'{REQ_SPARE_MID, 7'h2A, 16'h1234, 11'h001, 8'h5A, 1'b0}, 1'b1, RSP_IDLE},
      '{'{R_PROBE, 7'h7F, 16'hFFFF, 11'h7FF, 8'h00, 1'b0}, 1'b1, RSP_IDLE},
      '{'{R_READ, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b1, RSP_REFUSED},
      '{'{R_WRITE, 7'h7F, 16'hFFFF, 11'h400, 8'hFF, 1'b1}, 1'b1, RSP_REFUSED},
      '{'{R_SUPPLY, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b1, RSP_REFUSED},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b1}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b1}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b1}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b1}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b1}, 1'b0, RSP_PREDICT},
      '{'{R_TICK, 7'h00, 16'h0000, 11'h000, 8'h00, 1'b0}, 1'b0, RSP_PREDICT}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   i2cm_pkg::i2cm_req_type req_data;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   i2cm_pkg::i2cm_rsp_type rsp_data;

   // bus model state
   logic [2:0]  bus_phase, xfer_stage;
   logic [1:0]  half_idx, xfer_mode;
   logic [3:0]  bit_cnt;
   logic [7:0]  shreg;
   logic        nack_seen;
   logic [15:0] tick_cnt, word_buf, mem_addr, half_ticks;
   logic [10:0] count_left;
   logic [6:0]  tgt_addr;

   i2cm_pkg::i2cm_rsp_type bus_result_q[$];
   int unsigned err_cnt = 0;
   int unsigned cycle_cnt = 0;
   int unsigned n_items = 0, n_words = 0, n_done = 0, n_nack = 0, n_refused = 0;
   int unsigned n_settings = 0;
   int unsigned send_gap_pct = 0, rcv_stall_pct = 0;
   logic pressure_go = 1'b0;

   i2c_master_mem16_transactions_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_cnt <= cycle_cnt + 1;

   initial begin
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void enter_phase(input logic [2:0] ph);
      bus_phase = ph;
      half_idx  = 2'd0;
   endfunction

   function automatic void load_byte(input logic [7:0] b);
      enter_phase(i2cm_pkg::PH_TXBIT);
      bit_cnt = 4'd0;
      shreg   = b;
   endfunction

   function automatic void start_rx();
      enter_phase(i2cm_pkg::PH_RXBIT);
      bit_cnt = 4'd0;
   endfunction

   // One accepted transfer through the bus model; returns the result after it.
   function automatic i2cm_pkg::i2cm_rsp_type bus_step(input i2cm_pkg::i2cm_req_type r);
      i2cm_pkg::i2cm_rsp_type o;
      logic [10:0] cnt;
      logic sda;
      o   = '0;
      sda = r.sda_in;
      case (r.req_type)
         i2cm_pkg::REQ_TICK: begin
            if (bus_phase != i2cm_pkg::PH_IDLE && bus_phase != i2cm_pkg::PH_WAIT) begin
               if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, half_ticks}) begin
                  tick_cnt = '0;
                  case (bus_phase)
                     i2cm_pkg::PH_START: begin
                        if (half_idx < 2'd3) half_idx = half_idx + 2'd1;
                        else begin
                           enter_phase(i2cm_pkg::PH_TXBIT);
                           bit_cnt = 4'd0;
                        end
                     end
                     i2cm_pkg::PH_TXBIT, i2cm_pkg::PH_RXBIT: begin
                        if (half_idx == 2'd0) half_idx = 2'd1;
                        else begin
                           shreg = {shreg[6:0],
                                    (bus_phase == i2cm_pkg::PH_RXBIT) ? sda : 1'b0};
                           bit_cnt  = bit_cnt + 4'd1;
                           half_idx = 2'd0;
                           if (bit_cnt >= 4'd8) begin
                              bus_phase = (bus_phase == i2cm_pkg::PH_RXBIT) ?
                                          i2cm_pkg::PH_RXACK : i2cm_pkg::PH_TXACK;
                              bit_cnt   = 4'd0;
                           end
                        end
                     end
                     i2cm_pkg::PH_TXACK: begin
                        if (half_idx == 2'd0) half_idx = 2'd1;
                        else if (sda) begin
                           nack_seen = 1'b1;
                           enter_phase(i2cm_pkg::PH_STOP);
                        end else begin
                           case (xfer_stage)
                              i2cm_pkg::STG_ADDR_W: begin
                                 if (xfer_mode == i2cm_pkg::MODE_PROBE)
                                    enter_phase(i2cm_pkg::PH_STOP);
                                 else begin
                                    xfer_stage = i2cm_pkg::STG_REG_HI;
                                    load_byte(mem_addr[15:8]);
                                 end
                              end
                              i2cm_pkg::STG_REG_HI: begin
                                 xfer_stage = i2cm_pkg::STG_REG_LO;
                                 load_byte(mem_addr[7:0]);
                              end
                              i2cm_pkg::STG_REG_LO: begin
                                 if (xfer_mode == i2cm_pkg::MODE_READ) begin
                                    xfer_stage = i2cm_pkg::STG_ADDR_R;
                                    enter_phase(i2cm_pkg::PH_START);
                                    shreg = {tgt_addr, 1'b1};
                                 end else begin
                                    xfer_stage = i2cm_pkg::STG_DATA_W;
                                    enter_phase(i2cm_pkg::PH_WAIT);
                                 end
                              end
                              i2cm_pkg::STG_ADDR_R: begin
                                 xfer_stage = i2cm_pkg::STG_RX_HI;
                                 start_rx();
                              end
                              i2cm_pkg::STG_DATA_W: begin
                                 if (count_left != '0) count_left = count_left - 11'd1;
                                 if (count_left == '0) enter_phase(i2cm_pkg::PH_STOP);
                                 else enter_phase(i2cm_pkg::PH_WAIT);
                              end
                              default: enter_phase(i2cm_pkg::PH_STOP);
                           endcase
                        end
                     end
                     i2cm_pkg::PH_RXACK: begin
                        if (half_idx == 2'd0) half_idx = 2'd1;
                        else if (xfer_stage == i2cm_pkg::STG_RX_HI) begin
                           word_buf   = {shreg, 8'h00};
                           xfer_stage = i2cm_pkg::STG_RX_LO;
                           start_rx();
                        end else begin
                           word_buf     = {word_buf[15:8], shreg};
                           o.word_valid = 1'b1;
                           o.word_data  = word_buf;
                           o.last_word  = (count_left <= 11'd1);
                           if (count_left != '0) count_left = count_left - 11'd1;
                           if (count_left == '0) enter_phase(i2cm_pkg::PH_STOP);
                           else begin
                              xfer_stage = i2cm_pkg::STG_RX_HI;
                              start_rx();
                           end
                        end
                     end
                     i2cm_pkg::PH_STOP: begin
                        if (half_idx == 2'd0) half_idx = 2'd1;
                        else begin
                           enter_phase(i2cm_pkg::PH_IDLE);
                           o.done_res = 1'b1;
                           o.status   = nack_seen ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  tick_cnt = tick_cnt + 16'd1;
               end
            end
         end
         i2cm_pkg::REQ_PROBE, i2cm_pkg::REQ_READ, i2cm_pkg::REQ_WRITE: begin
            if (bus_phase == i2cm_pkg::PH_IDLE) begin
               cnt = r.xfer_count;
               if (cnt == '0) cnt = 11'd1;
               if (cnt > i2cm_pkg::MAX_COUNT) cnt = i2cm_pkg::MAX_COUNT;
               xfer_mode  = r.req_type[1:0];
               tgt_addr   = r.dev_addr;
               mem_addr   = r.reg_addr;
               count_left = cnt;
               xfer_stage = i2cm_pkg::STG_ADDR_W;
               nack_seen  = 1'b0;
               bit_cnt    = 4'd0;
               shreg      = {r.dev_addr, 1'b0};
               bus_phase  = i2cm_pkg::PH_START;
               half_idx   = 2'd1;
               tick_cnt   = '0;
            end else begin
               o.status = i2cm_pkg::ST_BUSY;
            end
         end
         i2cm_pkg::REQ_SUPPLY: begin
            if (bus_phase == i2cm_pkg::PH_WAIT) begin
               load_byte(r.wr_byte);
               tick_cnt = '0;
            end else begin
               o.status = i2cm_pkg::ST_BUSY;
            end
         end
         default: ;
      endcase

      case (bus_phase)
         i2cm_pkg::PH_START: begin
            o.scl_level = (half_idx == 2'd1 || half_idx == 2'd2);
            o.sda_level = (half_idx < 2'd2);
         end
         i2cm_pkg::PH_TXBIT: begin
            o.scl_level = half_idx[0];
            o.sda_level = shreg[7];
         end
         i2cm_pkg::PH_TXACK, i2cm_pkg::PH_RXBIT: begin
            o.scl_level = half_idx[0];
            o.sda_level = 1'b1;
         end
         i2cm_pkg::PH_RXACK: begin
            o.scl_level = half_idx[0];
            o.sda_level = (xfer_stage == i2cm_pkg::STG_RX_LO && count_left <= 11'd1);
         end
         i2cm_pkg::PH_STOP: begin
            o.scl_level = half_idx[0];
            o.sda_level = 1'b0;
         end
         i2cm_pkg::PH_WAIT: begin
            o.scl_level = 1'b0;
            o.sda_level = 1'b1;
         end
         default: begin
            o.scl_level = 1'b1;
            o.sda_level = 1'b1;
         end
      endcase
      o.need_byte = (bus_phase == i2cm_pkg::PH_WAIT);
      return o;
   endfunction

   // Picks the next request from the modelled bus state: mostly well-formed
   // transactions, with refused, misplaced and spare requests mixed in.
   function automatic i2cm_pkg::i2cm_req_type next_request();
      i2cm_pkg::i2cm_req_type it;
      int unsigned roll, pick, nack_pct;
      it = '0;
      it.dev_addr   = 7'($urandom);
      it.reg_addr   = 16'($urandom);
      it.xfer_count = 11'($urandom);
      it.wr_byte    = 8'($urandom);
      it.sda_in     = 1'($urandom);
      roll = $urandom_range(99);
      if (bus_phase == i2cm_pkg::PH_IDLE) begin
         if (roll < 80) begin
            it.req_type = 3'($urandom_range(R_PROBE, R_WRITE));
            pick = $urandom_range(99);
            if (pick < 80) it.xfer_count = 11'($urandom_range(1, 3));
            else if (pick < 88) it.xfer_count = '0;
            else if (pick < 95) it.xfer_count = 11'($urandom_range(4, 12));
            else it.xfer_count = 11'($urandom_range(i2cm_pkg::MAX_COUNT + 11'd1, 11'h7FF));
            if (it.req_type == R_READ && it.xfer_count > 11'd12)
               it.xfer_count = 11'($urandom_range(1, 3));
         end else if (roll < 90) it.req_type = R_TICK;
         else if (roll < 95) it.req_type = R_SUPPLY;
         else it.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      end else if (bus_phase == i2cm_pkg::PH_WAIT) begin
         if (roll < 80) it.req_type = R_SUPPLY;
         else if (roll < 90) it.req_type = R_TICK;
         else if (roll < 95) it.req_type = 3'($urandom_range(R_PROBE, R_WRITE));
         else it.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      end else begin
         if (roll < 92) it.req_type = R_TICK;
         else if (roll < 95) it.req_type = 3'($urandom_range(R_PROBE, R_WRITE));
         else if (roll < 97) it.req_type = R_SUPPLY;
         else it.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
         if (bus_phase == i2cm_pkg::PH_TXACK && half_idx == 2'd1) begin
            // long writes are cut short by the slave
            if (count_left > 11'd12)
               nack_pct = (xfer_mode == i2cm_pkg::MODE_READ) ? 0 : 50;
            else nack_pct = 6;
            it.sda_in = ($urandom_range(99) < nack_pct);
         end
      end
      return it;
   endfunction

   task automatic send_item(input i2cm_pkg::i2cm_req_type item, input logic typed,
                            input i2cm_pkg::i2cm_rsp_type typed_rsp);
      i2cm_pkg::i2cm_rsp_type pred;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pred = bus_step(item);
      bus_result_q.push_back(typed ? typed_rsp : pred);
      n_items++;
      if (pred.word_valid) n_words++;
      if (pred.done_res) n_done++;
      if (pred.done_res && pred.status == i2cm_pkg::ST_NACK) n_nack++;
      if (pred.status == i2cm_pkg::ST_BUSY) n_refused++;
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) send_item(next_request(), 1'b0, RSP_PREDICT);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (bus_result_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_half_period(input logic [15:0] ticks);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      half_ticks  = ticks;
      n_settings++;
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         err_cnt++;
      end
   endfunction

   always @(posedge clock) begin : result_side
      int unsigned hold_left;
      logic pressure_taken;
      i2cm_pkg::i2cm_rsp_type want;
      if (reset) begin
         rsp_stall      <= 1'b0;
         hold_left      = 0;
         pressure_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bus_result_q.size() == 0) begin
               $error("result with nothing outstanding: %p", rsp_data);
               err_cnt++;
            end else begin
               want = bus_result_q.pop_front();
               check_field("scl_level", 16'(want.scl_level), 16'(rsp_data.scl_level));
               check_field("sda_level", 16'(want.sda_level), 16'(rsp_data.sda_level));
               check_field("need_byte", 16'(want.need_byte), 16'(rsp_data.need_byte));
               check_field("word_valid", 16'(want.word_valid), 16'(rsp_data.word_valid));
               check_field("word_data", want.word_data, rsp_data.word_data);
               check_field("last_word", 16'(want.last_word), 16'(rsp_data.last_word));
               check_field("done_res", 16'(want.done_res), 16'(rsp_data.done_res));
               check_field("status", 16'(want.status), 16'(rsp_data.status));
            end
         end
         if (pressure_go && !pressure_taken) begin
            pressure_taken = 1'b1;
            hold_left      = 80;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      i2cm_pkg::i2cm_req_type tick;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      bus_phase  = i2cm_pkg::PH_IDLE;
      xfer_stage = i2cm_pkg::STG_ADDR_W;
      half_idx   = '0;
      xfer_mode  = '0;
      bit_cnt    = '0;
      shreg      = '0;
      nack_seen  = 1'b0;
      tick_cnt   = '0;
      word_buf   = '0;
      mem_addr   = '0;
      count_left = '0;
      tgt_addr   = '0;
      half_ticks = i2cm_pkg::HALF_PERIOD_INIT;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_item(DIR_TABLE[i].item, DIR_TABLE[i].typed, DIR_TABLE[i].rsp);
      drain();

      send_gap_pct  = 27;
      rcv_stall_pct = 60;
      set_half_period(16'd1);
      pressure_go <= 1'b1;
      run_random(220);
      drain();

      send_gap_pct  = 60;
      rcv_stall_pct = 27;
      set_half_period(16'd0);
      run_random(220);
      drain();

      // slow clock, then shorten it with the tick count already past the new value
      set_half_period(16'hFFFF);
      while (bus_phase == i2cm_pkg::PH_IDLE || bus_phase == i2cm_pkg::PH_WAIT)
         send_item(next_request(), 1'b0, RSP_PREDICT);
      repeat (6) begin
         tick          = '0;
         tick.req_type = R_TICK;
         tick.sda_in   = 1'($urandom);
         send_item(tick, 1'b0, RSP_PREDICT);
      end
      drain();

      send_gap_pct  = 0;
      rcv_stall_pct = 0;
      set_half_period(16'd2);
      run_random(200);
      drain();
      repeat (4) @(posedge clock);

      $display("Run covered %0d transfers over %0d half-period settings.", n_items,
               n_settings + 1);
      $display("Words read %0d, transactions closed %0d (%0d on NACK), refused %0d.",
               n_words, n_done, n_nack, n_refused);
      if (err_cnt == 0 && bus_result_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
